// File: src/kne_pkg.sv
// ----------------------------------------------------------------------------
// kne_pkg
// Shared types, constants and small lookup functions for the keyword
// number extractor.
// ----------------------------------------------------------------------------
package kne_pkg;

    localparam int KW_LEN      = 6;
    localparam int FRAC_DIGITS = 3;
    localparam int INT_W       = 32;
    localparam int FRAC_W      = 10;
    localparam int TOTAL_W     = 42;

    localparam logic [INT_W-1:0] OUT_MAX = {INT_W{1'b1}};

    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef logic [2:0] t_match;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_SECTION = 2'd1,
        PH_NUMBER  = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    // Snapshot of the number state taken on the last byte of a text
    typedef struct packed {
        logic              found;
        logic              overflow;
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac_part;
        logic [1:0]        frac_count;
    } t_fin;

    // Keyword APPMAG, one letter per index
    function automatic logic [7:0] kw_char(input t_match idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h41;  // A
            3'd1:    c = 8'h50;  // P
            3'd2:    c = 8'h50;  // P
            3'd3:    c = 8'h4D;  // M
            3'd4:    c = 8'h41;  // A
            3'd5:    c = 8'h47;  // G
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Length of the longest proper prefix that is also a suffix of the
    // first idx matched letters
    function automatic t_match kw_fall(input t_match idx);
        t_match f;
        case (idx)
            3'd5:    f = 3'd1;
            default: f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [FRAC_W-1:0] pow10(input logic [1:0] e);
        logic [FRAC_W-1:0] p;
        case (e)
            2'd0:    p = 10'd1;
            2'd1:    p = 10'd10;
            2'd2:    p = 10'd100;
            default: p = 10'd1000;
        endcase
        return p;
    endfunction

endpackage

// File: src/keyword_number_extractor_core.sv
// ----------------------------------------------------------------------------
// keyword_number_extractor_core
// Finds the keyword APPMAG in a byte stream and returns the first decimal
// number that follows it, scaled to thousandths.
// ----------------------------------------------------------------------------
// The block takes one text byte per transfer on the slave side, tlast on the
// final byte of the text. Bytes are folded to upper case and matched against
// APPMAG; partial matches fall back so overlapping keywords are still seen.
// After a match the section up to the next '|' is read and the first number
// (digits with at most one point) is captured; a section without digits
// resumes the keyword search at the '|'. Once a number has ended, later
// bytes are ignored. Each text produces exactly one result transfer, issued
// after its tlast byte: found, the value times 1000 (fraction truncated to
// three digits) and a saturation flag, with value pinned at 4294967295 when
// the number does not fit. Throughput is one byte per clock. The tlast
// transfer loads the input register, the snapshot register follows (state
// update), then the output register (x1000 scaling), which drives
// m_axis_tvalid. Ordinary bytes keep flowing while results wait on the
// master side; a tlast byte stalls only while both the snapshot and the
// output register hold untaken results.
module keyword_number_extractor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [0] found, [32:1] value_milli,
                                        // [33] saturated, [39:34] zero
);

    // ---------------- input register ----------------
    logic       r_in_valid;
    logic       r_in_last;
    logic [7:0] r_in_ch;

    // ---------------- scan state ----------------
    kne_pkg::t_phase                 r_phase,      n_phase;
    kne_pkg::t_match                 r_match,      n_match;
    logic [kne_pkg::INT_W-1:0]       r_int,        n_int;
    logic [kne_pkg::FRAC_W-1:0]      r_frac,       n_frac;
    logic [1:0]                      r_frac_cnt,   n_frac_cnt;
    logic                            r_point,      n_point;
    logic                            r_ovf,        n_ovf;

    // ---------------- snapshot and output registers ----------------
    logic                            r_fin_valid;
    kne_pkg::t_fin                   r_fin;
    logic                            r_out_valid;
    logic                            r_out_found;
    logic [kne_pkg::INT_W-1:0]       r_out_value;
    logic                            r_out_sat;

    // ---------------- flow control ----------------
    logic out_adv;   // output register may load
    logic fin_adv;   // snapshot register may load
    logic proc;      // byte in the input register is consumed this cycle

    assign out_adv       = !r_out_valid || m_axis_tready;
    assign fin_adv       = !r_fin_valid || out_adv;
    // Only a tlast byte needs room downstream; others just update state
    assign proc          = r_in_valid && (!r_in_last || fin_adv);
    assign s_axis_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ch   <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // ---------------- byte classification ----------------
    logic [7:0] ch_up;
    logic       is_digit;
    logic [3:0] digit;

    always_comb begin
        ch_up = r_in_ch;
        if (r_in_ch >= kne_pkg::CH_A_LO && r_in_ch <= kne_pkg::CH_Z_LO) begin
            ch_up = r_in_ch - kne_pkg::CASE_OFS;
        end
    end

    assign is_digit = (ch_up >= kne_pkg::CH_ZERO) && (ch_up <= kne_pkg::CH_NINE);
    assign digit    = 4'(ch_up - kne_pkg::CH_ZERO);

    // ---------------- keyword matcher ----------------
    kne_pkg::t_match k_cur;
    kne_pkg::t_match k_fall;
    kne_pkg::t_match k_next;

    always_comb begin
        k_cur  = (r_match >= 3'(kne_pkg::KW_LEN)) ? 3'd0 : r_match;
        k_fall = kne_pkg::kw_fall(k_cur);
        if (ch_up == kne_pkg::kw_char(k_cur)) begin
            k_next = k_cur + 3'd1;
        end else if (k_fall != 3'd0 && ch_up == kne_pkg::kw_char(k_fall)) begin
            k_next = k_fall + 3'd1;
        end else if (ch_up == kne_pkg::kw_char(3'd0)) begin
            k_next = 3'd1;
        end else begin
            k_next = 3'd0;
        end
    end

    // ---------------- next state: phase and match count ----------------
    always_comb begin
        n_phase = r_phase;
        n_match = r_match;
        case (r_phase)
            kne_pkg::PH_SEARCH: begin
                if (k_next >= 3'(kne_pkg::KW_LEN)) begin
                    n_match = 3'd0;
                    n_phase = kne_pkg::PH_SECTION;
                end else begin
                    n_match = k_next;
                end
            end
            kne_pkg::PH_SECTION: begin
                if (ch_up == kne_pkg::CH_BAR) begin
                    n_phase = kne_pkg::PH_SEARCH;
                    n_match = 3'd0;
                end else if (is_digit) begin
                    n_phase = kne_pkg::PH_NUMBER;
                end
            end
            kne_pkg::PH_NUMBER: begin
                if (!is_digit && !(ch_up == kne_pkg::CH_POINT && !r_point)) begin
                    n_phase = kne_pkg::PH_DONE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // ---------------- next state: number accumulator ----------------
    logic        take_digit;
    logic [35:0] int_x10;

    assign take_digit = is_digit &&
                        (r_phase == kne_pkg::PH_SECTION || r_phase == kne_pkg::PH_NUMBER);
    assign int_x10    = 36'(r_int) * 36'd10 + 36'(digit);

    always_comb begin
        n_int      = r_int;
        n_frac     = r_frac;
        n_frac_cnt = r_frac_cnt;
        n_point    = r_point;
        n_ovf      = r_ovf;
        if (take_digit) begin
            if (r_point) begin
                // Keep only the first fraction digits, drop the rest
                if (r_frac_cnt < 2'(kne_pkg::FRAC_DIGITS)) begin
                    n_frac     = 10'(r_frac * 10'd10 + 10'(digit));
                    n_frac_cnt = r_frac_cnt + 2'd1;
                end
            end else if (!r_ovf) begin
                if (int_x10 > 36'(kne_pkg::OUT_MAX)) begin
                    n_ovf = 1'b1;
                    n_int = kne_pkg::OUT_MAX;
                end else begin
                    n_int = int_x10[kne_pkg::INT_W-1:0];
                end
            end
        end else if (r_phase == kne_pkg::PH_NUMBER && ch_up == kne_pkg::CH_POINT) begin
            n_point = 1'b1;
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= kne_pkg::PH_SEARCH;
            r_match    <= 3'd0;
            r_int      <= '0;
            r_frac     <= '0;
            r_frac_cnt <= 2'd0;
            r_point    <= 1'b0;
            r_ovf      <= 1'b0;
        end else if (proc) begin
            if (r_in_last) begin
                // Text finished: clear for the next one
                r_phase    <= kne_pkg::PH_SEARCH;
                r_match    <= 3'd0;
                r_int      <= '0;
                r_frac     <= '0;
                r_frac_cnt <= 2'd0;
                r_point    <= 1'b0;
                r_ovf      <= 1'b0;
            end else begin
                r_phase    <= n_phase;
                r_match    <= n_match;
                r_int      <= n_int;
                r_frac     <= n_frac;
                r_frac_cnt <= n_frac_cnt;
                r_point    <= n_point;
                r_ovf      <= n_ovf;
            end
        end
    end

    // ---------------- snapshot on the last byte ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin_adv) begin
            r_fin_valid <= proc && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_adv && proc && r_in_last) begin
            r_fin.found      <= (n_phase == kne_pkg::PH_NUMBER) ||
                                (n_phase == kne_pkg::PH_DONE);
            r_fin.overflow   <= n_ovf;
            r_fin.int_part   <= n_int;
            r_fin.frac_part  <= n_frac;
            r_fin.frac_count <= n_frac_cnt;
        end
    end

    // ---------------- scaling to thousandths ----------------
    logic [19:0]                   frac_milli;
    logic [kne_pkg::TOTAL_W-1:0]   total;
    logic                          res_sat;
    logic [kne_pkg::INT_W-1:0]     res_value;

    assign frac_milli = 20'(r_fin.frac_part) * 20'(kne_pkg::pow10(2'd3 - r_fin.frac_count));
    assign total      = 42'(r_fin.int_part) * 42'd1000 + 42'(frac_milli);

    always_comb begin
        res_sat   = 1'b0;
        res_value = '0;
        if (r_fin.found) begin
            if (r_fin.overflow || total > 42'(kne_pkg::OUT_MAX)) begin
                res_sat   = 1'b1;
                res_value = kne_pkg::OUT_MAX;
            end else begin
                res_value = total[kne_pkg::INT_W-1:0];
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_fin_valid) begin
            r_out_found <= r_fin.found;
            r_out_value <= res_value;
            r_out_sat   <= res_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_sat, r_out_value, r_out_found};

endmodule
